// ===== hw/rtl/image_rotate_shift_augment_core_assert.svh =====
// Assertion macros for the image rotate/shift augmenter port-level checker.
`ifndef IMAGE_ROTATE_SHIFT_AUGMENT_CORE_ASSERT_SVH
`define IMAGE_ROTATE_SHIFT_AUGMENT_CORE_ASSERT_SVH

// Checked only while out of reset.
`define IRSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define IRSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/irsa_pkg.sv =====
// Package: shared constants, codes and types of the image rotate/shift augmenter.
`timescale 1ns / 1ps

package irsa_pkg;

  // Parameter defaults
  localparam int unsigned ImgWDef     = 28;
  localparam int unsigned ImgHDef     = 28;
  localparam int unsigned PixelBitsDef = 8;

  // Fixed field widths
  localparam int unsigned ReqW    = 2;
  localparam int unsigned CoordW  = 5;
  localparam int unsigned PixW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned ShiftW  = 4;

  // Datapath widths
  localparam int unsigned FracW   = 14;
  localparam int unsigned DeltaW  = 8;   // signed centred / displaced coordinate
  localparam int unsigned ProdW   = DeltaW + CfgW;
  localparam int unsigned SumW    = ProdW + 3;
  localparam int unsigned TruncW  = SumW - FracW;

  // Store generation tag; a clear bumps it, a wrap forces a sweep
  localparam int unsigned EpochW  = 8;

  typedef enum logic [ReqW-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_READ  = 2'd2
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COS        = 2'd0,
    CFG_SIN        = 2'd1,
    CFG_SHIFT_ROWS = 2'd2,
    CFG_SHIFT_COLS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic wr;
    logic rd;
    logic clr;
  } store_ctl_t;

endpackage

// ===== hw/rtl/irsa_store.sv =====
// Rotated image store with per-entry generation tags and a clearing sweep.
`timescale 1ns / 1ps

module irsa_store import irsa_pkg::*; #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_ctl_t       ctl_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wr_data_i,
  output logic             busy_o,
  output logic             rd_hit_o,
  output logic [DataW-1:0] rd_data_o
);

  localparam int unsigned Depth = 2 ** AddrW;
  localparam int unsigned WordW = EpochW + DataW;

  logic [WordW-1:0]  mem_q [Depth];
  logic [WordW-1:0]  rd_q;
  logic [EpochW-1:0] snap_q;

  logic              sweep_q, sweep_d;
  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic [EpochW-1:0] epoch_q, epoch_d;

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [WordW-1:0]  wr_word;

  always_comb begin
    sweep_d = sweep_q;
    cnt_d   = cnt_q;
    epoch_d = epoch_q;
    wr_en   = 1'b0;
    wr_addr = addr_i;
    wr_word = {epoch_q, wr_data_i};
    if (sweep_q) begin
      // tag 0 is never a live generation
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_word = '0;
      cnt_d   = cnt_q + 1'b1;
      if (&cnt_q) begin
        sweep_d = 1'b0;
      end
    end else if (ctl_i.clr) begin
      if (&epoch_q) begin
        epoch_d = EpochW'(1);
        sweep_d = 1'b1;
        cnt_d   = '0;
      end else begin
        epoch_d = epoch_q + 1'b1;
      end
    end else if (ctl_i.wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= 1'b1;
      cnt_q   <= '0;
      epoch_q <= EpochW'(1);
    end else begin
      sweep_q <= sweep_d;
      cnt_q   <= cnt_d;
      epoch_q <= epoch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (ctl_i.rd) begin
      rd_q   <= mem_q[addr_i];
      snap_q <= epoch_q;
    end
  end

  assign busy_o    = sweep_q;
  assign rd_hit_o  = (rd_q[WordW-1:DataW] == snap_q);
  assign rd_data_o = rd_q[DataW-1:0];

endmodule

// ===== hw/rtl/image_rotate_shift_augment_core.sv =====
// Image rotate/shift augmenter: nearest-neighbor forward-scatter rotation plus shifted readout.
// One item per clock when not stalled: an item sits in the input register while its target
// address is computed (two 8x16 products per coordinate, add, truncate toward
// zero, bounds check), then a load writes the store or a read reads it; the
// registered read data feeds the output register, so a read's result passes
// the input, store read and output registers in turn. The single
// read/write port of the store sets the rate. Stores are tagged with a
// generation number; a clear just bumps it. After reset, and again on every
// 255th clear, a clearing sweep rewrites all 2**(clog2(IMG_H)+clog2(IMG_W))
// entries (1024 of them at 28x28), during which in_stall_o stays high.
// Configuration writes are always taken; write them only while the block is idle.
`timescale 1ns / 1ps

module image_rotate_shift_augment_core import irsa_pkg::*; #(
  parameter int unsigned IMG_W      = ImgWDef,
  parameter int unsigned IMG_H      = ImgHDef,
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ReqW-1:0]    req_type_i,
  input  logic [CoordW-1:0]  row_i,
  input  logic [CoordW-1:0]  col_i,
  input  logic [PixW-1:0]    pixel_in_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PixW-1:0]    pixel_out_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned DataW = (PIXEL_BITS < PixW) ? PIXEL_BITS : PixW;
  localparam int unsigned ColAw = $clog2(IMG_W);
  localparam int unsigned RowAw = $clog2(IMG_H);
  localparam int unsigned AddrW = RowAw + ColAw;

  localparam logic signed [DeltaW-1:0] HalfW   = DeltaW'(IMG_W / 2);
  localparam logic signed [DeltaW-1:0] HalfH   = DeltaW'(IMG_H / 2);
  localparam logic signed [DeltaW-1:0] LimW    = DeltaW'(IMG_W);
  localparam logic signed [DeltaW-1:0] LimH    = DeltaW'(IMG_H);
  localparam logic signed [SumW-1:0]   CenterX = SumW'((IMG_W / 2) * (2 ** FracW));
  localparam logic signed [SumW-1:0]   CenterY = SumW'((IMG_H / 2) * (2 ** FracW));
  localparam logic signed [SumW-1:0]   TruncBias = SumW'((2 ** FracW) - 1);
  localparam logic signed [TruncW-1:0] TgtLimW = TruncW'(IMG_W);
  localparam logic signed [TruncW-1:0] TgtLimH = TruncW'(IMG_H);

  // Configuration registers
  logic signed [CfgW-1:0]   cos_q, sin_q;
  logic signed [ShiftW-1:0] shift_rows_q, shift_cols_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q        <= CfgW'(16384);
      sin_q        <= '0;
      shift_rows_q <= '0;
      shift_cols_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COS:        cos_q        <= cfg_data_i;
        CFG_SIN:        sin_q        <= cfg_data_i;
        CFG_SHIFT_ROWS: shift_rows_q <= cfg_data_i[ShiftW-1:0];
        CFG_SHIFT_COLS: shift_cols_q <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic              v1_q;
  logic [ReqW-1:0]   req1_q;
  logic [CoordW-1:0] row1_q, col1_q;
  logic [DataW-1:0]  pix1_q;

  // Read in flight (data held in the store's read register), then output register
  logic              v2_q, ok2_q;
  logic              ov_q;
  logic [PixW-1:0]   pix_out_q;

  logic              busy, rd_hit;
  logic [DataW-1:0]  rd_data;
  store_ctl_t        ctl;
  logic [AddrW-1:0]  addr;

  logic adv3, adv2, go1, accept, move23;

  assign adv3   = !ov_q || !out_stall_i;
  assign adv2   = !v2_q || adv3;
  assign go1    = v1_q && !busy && ((req1_q != REQ_READ) || adv2);
  assign in_stall_o = busy || (v1_q && !go1);
  assign accept = in_valid_i && !in_stall_o;
  assign move23 = v2_q && adv3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (accept) begin
      v1_q <= 1'b1;
    end else if (go1) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req1_q <= req_type_i;
      row1_q <= row_i;
      col1_q <= col_i;
      pix1_q <= pixel_in_i[DataW-1:0];
    end
  end

  // Forward map of a load
  logic signed [DeltaW-1:0] row_s, col_s, dx, dy;
  logic signed [ProdW-1:0]  p_xc, p_ys, p_xs, p_yc;
  logic signed [SumW-1:0]   sum_x, sum_y, adj_x, adj_y;
  logic signed [TruncW-1:0] nx, ny;
  logic                     src_ok, tgt_ok;

  // Displaced read position
  logic signed [DeltaW-1:0] rr, cc;
  logic                     rd_ok;
  logic [AddrW-1:0]         wr_addr, rd_addr;

  always_comb begin
    row_s = $signed({{(DeltaW - CoordW){1'b0}}, row1_q});
    col_s = $signed({{(DeltaW - CoordW){1'b0}}, col1_q});
    dx    = col_s - HalfW;
    dy    = row_s - HalfH;
    src_ok = (row_s < LimH) && (col_s < LimW);

    p_xc = dx * cos_q;
    p_ys = dy * sin_q;
    p_xs = dx * sin_q;
    p_yc = dy * cos_q;

    sum_x = SumW'(p_xc) + SumW'(p_ys) + CenterX;
    sum_y = SumW'(p_yc) - SumW'(p_xs) + CenterY;
    // round toward zero: bias negatives before the arithmetic shift
    adj_x = sum_x + (sum_x[SumW-1] ? TruncBias : '0);
    adj_y = sum_y + (sum_y[SumW-1] ? TruncBias : '0);
    nx    = adj_x[SumW-1:FracW];
    ny    = adj_y[SumW-1:FracW];
    tgt_ok = !nx[TruncW-1] && (nx < TgtLimW) && !ny[TruncW-1] && (ny < TgtLimH);
    wr_addr = {ny[RowAw-1:0], nx[ColAw-1:0]};

    rr = row_s - DeltaW'(shift_rows_q);
    cc = col_s - DeltaW'(shift_cols_q);
    rd_ok = src_ok && !rr[DeltaW-1] && (rr < LimH) && !cc[DeltaW-1] && (cc < LimW);
    rd_addr = {rr[RowAw-1:0], cc[ColAw-1:0]};

    ctl  = '0;
    addr = rd_addr;
    if (go1) begin
      case (req1_q)
        REQ_CLEAR: ctl.clr = 1'b1;
        REQ_LOAD: begin
          ctl.wr = src_ok && tgt_ok;
          addr   = wr_addr;
        end
        REQ_READ:  ctl.rd = 1'b1;
        default: ;
      endcase
    end
  end

  irsa_store #(
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .addr_i    (addr),
    .wr_data_i (pix1_q),
    .busy_o    (busy),
    .rd_hit_o  (rd_hit),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ctl.rd) begin
        v2_q <= 1'b1;
      end else if (move23) begin
        v2_q <= 1'b0;
      end
      if (move23) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.rd) begin
      ok2_q <= rd_ok;
    end
    if (move23) begin
      pix_out_q <= (ok2_q && rd_hit) ? PixW'(rd_data) : '0;
    end
  end

  assign out_valid_o = ov_q;
  assign pixel_out_o = pix_out_q;

endmodule

// ===== hw/rtl/irsa_checker.sv =====
// Port-level checker for the image rotate/shift augmenter, bound to the top level.
`timescale 1ns / 1ps
`include "image_rotate_shift_augment_core_assert.svh"

module irsa_checker import irsa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PixW-1:0]    pixel_out_o
);

  `IRSA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")
  `IRSA_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(pixel_out_o), "stalled result changed")
  `IRSA_ASSERT_ALWAYS(a_sweep_after_reset, !rst_ni |=> in_stall_o, "items taken before store sweep")
  `IRSA_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result shown during reset")

endmodule

bind image_rotate_shift_augment_core irsa_checker u_irsa_checker (.*);

// ===== sim/irsa_pixel_checker.sv =====
// Checker for the image rotate/shift augmenter: shadow image store, read prediction, compare.
`timescale 1ns / 1ps

module irsa_pixel_checker import irsa_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [ReqW-1:0]              req_type_i,
  input  logic [CoordW-1:0]            row_i,
  input  logic [CoordW-1:0]            col_i,
  input  logic [PixW-1:0]              pixel_in_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [PixW-1:0]              pixel_out_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [CfgW-1:0]              cfg_data_i,
  output int unsigned                  err_count_o,
  output int unsigned                  pending_o,
  output logic [ImgWDef*ImgHDef-1:0]   landed_o
);

  localparam int ImgW            = ImgWDef;
  localparam int ImgH            = ImgHDef;
  localparam int Cells           = ImgW * ImgH;
  localparam int CosOne          = 1 << FracW;
  localparam longint Unit        = longint'(1) << FracW;
  localparam logic [PixW-1:0] PixMask = PixW'((1 << PixelBitsDef) - 1);

  logic [PixW-1:0]  image_mem [Cells];
  logic [Cells-1:0] filled;
  logic [Cells-1:0] ever_landed;
  int               cos_r, sin_r, shift_rows_r, shift_cols_r;
  int unsigned      fails;
  logic [PixW-1:0]  want_pixels_q [$];
  logic [PixW-1:0]  want;

  function automatic void note_failure(string what);
    fails++;
    if (fails <= 10) $display("%0t: %s", $time, what);
  endfunction

  // forward scatter of one source pixel, rotated about the image center
  function automatic void scatter_pixel(int row, int col, logic [PixW-1:0] pix);
    int dx, dy;
    longint sx, sy, nx, ny;
    if (row >= ImgH || col >= ImgW) return;
    dx = col - ImgW / 2;
    dy = row - ImgH / 2;
    sx = longint'(dx) * cos_r + longint'(dy) * sin_r + longint'(ImgW / 2) * Unit;
    sy = longint'(dy) * cos_r - longint'(dx) * sin_r + longint'(ImgH / 2) * Unit;
    // signed division truncates toward zero
    nx = sx / Unit;
    ny = sy / Unit;
    if (nx >= 0 && nx < ImgW && ny >= 0 && ny < ImgH) begin
      image_mem[ny * ImgW + nx]   = pix & PixMask;
      filled[ny * ImgW + nx]      = 1'b1;
      ever_landed[ny * ImgW + nx] = 1'b1;
    end
  endfunction

  function automatic logic [PixW-1:0] fetch_pixel(int row, int col);
    int r, c;
    if (row >= ImgH || col >= ImgW) return '0;
    r = row - shift_rows_r;
    c = col - shift_cols_r;
    if (r < 0 || r >= ImgH || c < 0 || c >= ImgW) return '0;
    // nothing landed here since the last clear
    if (!filled[r * ImgW + c]) return '0;
    return image_mem[r * ImgW + c];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled       = '0;
      ever_landed  = '0;
      cos_r        = CosOne;
      sin_r        = 0;
      shift_rows_r = 0;
      shift_cols_r = 0;
      fails        = 0;
      want_pixels_q.delete();
      err_count_o  <= 0;
      pending_o    <= 0;
      landed_o     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_COS:        cos_r        = int'($signed(cfg_data_i));
          CFG_SIN:        sin_r        = int'($signed(cfg_data_i));
          CFG_SHIFT_ROWS: shift_rows_r = int'($signed(cfg_data_i[ShiftW-1:0]));
          CFG_SHIFT_COLS: shift_cols_r = int'($signed(cfg_data_i[ShiftW-1:0]));
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (want_pixels_q.size() == 0) begin
          note_failure($sformatf("unexpected pixel_out %0d", pixel_out_i));
        end else begin
          want = want_pixels_q.pop_front();
          if (pixel_out_i !== want)
            note_failure($sformatf("pixel_out %0d, expected %0d", pixel_out_i, want));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (req_type_i)
          REQ_CLEAR: filled = '0;
          REQ_LOAD:  scatter_pixel(int'(row_i), int'(col_i), pixel_in_i);
          REQ_READ:  want_pixels_q.push_back(fetch_pixel(int'(row_i), int'(col_i)));
          default: ;
        endcase
      end
      err_count_o <= fails;
      pending_o   <= want_pixels_q.size();
      landed_o    <= ever_landed;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the image rotate/shift augmenter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import irsa_pkg::*;

  localparam int ImgW        = ImgWDef;
  localparam int ImgH        = ImgHDef;
  localparam int Cells       = ImgW * ImgH;
  localparam int IdlePct     = 18;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 8;
  localparam int StallLimit  = 20000;
  localparam int PhaseItems  = 42;
  localparam int NumPhases   = 9;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ReqW-1:0]    req_type_i;
  logic [CoordW-1:0]  row_i;
  logic [CoordW-1:0]  col_i;
  logic [PixW-1:0]    pixel_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [PixW-1:0]    pixel_out_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;

  int unsigned        err_count;
  int unsigned        pending;
  logic [Cells-1:0]   landed;
  int                 sh_rows, sh_cols;
  int                 phase_items;
  int unsigned        idle_cycles;
  bit                 no_gaps, hold_go, hold_done;

  image_rotate_shift_augment_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  irsa_pixel_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .req_type_i  (req_type_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_i (pixel_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .err_count_o (err_count),
    .pending_o   (pending),
    .landed_o    (landed)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // no progress on any channel for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("image_rotate_shift_augment_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off while the sender keeps going
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= (!no_gaps && $urandom_range(99) < IdlePct);
    end
  end

  task automatic send_item(logic [ReqW-1:0] req, int row, int col, int pix, bit counted);
    while (!no_gaps && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    row_i      <= row[CoordW-1:0];
    col_i      <= col[CoordW-1:0];
    pixel_in_i <= pix[PixW-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (counted) phase_items++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_config(int cos_v, int sin_v, int rows_v, int cols_v);
    cfg_idx_e        order [4];
    logic [CfgW-1:0] vals [4];
    logic [31:0]     noise;
    int              i;
    order[0] = CFG_COS;
    order[1] = CFG_SIN;
    order[2] = CFG_SHIFT_ROWS;
    order[3] = CFG_SHIFT_COLS;
    vals[0]  = cos_v[CfgW-1:0];
    vals[1]  = sin_v[CfgW-1:0];
    // upper bits of a shift write are don't-care, so randomize them
    noise    = $urandom;
    vals[2]  = {noise[CfgW-1:ShiftW], rows_v[ShiftW-1:0]};
    noise    = $urandom;
    vals[3]  = {noise[CfgW-1:ShiftW], cols_v[ShiftW-1:0]};
    for (i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    sh_rows = int'($signed(rows_v[ShiftW-1:0]));
    sh_cols = int'($signed(cols_v[ShiftW-1:0]));
  endtask

  // read position that only ever touches stored pixels that were written at least once
  function automatic void pick_read(output int r, output int c);
    int  k, base, pos, lr, lc, tr, tc;
    bit  found;
    found = 1'b0;
    tr    = 0;
    tc    = 0;
    if ($urandom_range(99) < 30) begin
      tr = $urandom_range(31);
      tc = $urandom_range(31);
      if (tr >= ImgH || tc >= ImgW) begin
        found = 1'b1;
      end else begin
        lr = tr - sh_rows;
        lc = tc - sh_cols;
        found = (lr < 0 || lr >= ImgH || lc < 0 || lc >= ImgW || landed[lr * ImgW + lc]);
      end
    end else begin
      base = $urandom_range(Cells - 1);
      for (k = 0; k < Cells && !found; k++) begin
        pos = (base + k) % Cells;
        if (landed[pos]) begin
          tr = pos / ImgW + sh_rows;
          tc = pos % ImgW + sh_cols;
          found = (tr >= 0 && tr < ImgH && tc >= 0 && tc < ImgW);
        end
      end
    end
    if (!found) begin
      if ($urandom_range(1)) begin
        tr = $urandom_range(31, ImgH);
        tc = $urandom_range(31);
      end else begin
        tr = $urandom_range(31);
        tc = $urandom_range(31, ImgW);
      end
    end
    r = tr;
    c = tc;
  endfunction

  task automatic run_phase(int target);
    int                roll, h, w, r0, c0, i, j, nreads;
    int                rr, cc;
    phase_items = 0;
    while (phase_items < target) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_item(ReqUnused, $urandom, $urandom, $urandom, 1'b0);
      end else if (roll < 10) begin
        // load from outside the source image
        if ($urandom_range(1))
          send_item(REQ_LOAD, $urandom_range(31, ImgH), $urandom, $urandom, 1'b0);
        else
          send_item(REQ_LOAD, $urandom, $urandom_range(31, ImgW), $urandom, 1'b0);
      end else if (roll < 16) begin
        send_item(REQ_CLEAR, $urandom, $urandom, $urandom, 1'b1);
      end else begin
        // a patch in raster order, then reads of the augmented image
        h  = $urandom_range(6, 1);
        w  = $urandom_range(8, 1);
        r0 = $urandom_range(ImgH - h);
        c0 = $urandom_range(ImgW - w);
        for (i = 0; i < h; i++)
          for (j = 0; j < w; j++)
            send_item(REQ_LOAD, r0 + i, c0 + j, $urandom, 1'b1);
        nreads = $urandom_range(h * w / 2 + 1, 1);
        for (i = 0; i < nreads; i++) begin
          pick_read(rr, cc);
          send_item(REQ_READ, rr, cc, $urandom, 1'b1);
        end
      end
    end
  endtask

  initial begin
    int p;
    rst_ni      = 1'b1;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_CLEAR;
    row_i       = '0;
    col_i       = '0;
    pixel_in_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_COS;
    cfg_data_i  = '0;
    no_gaps     = 1'b0;
    hold_go     = 1'b0;
    sh_rows     = 0;
    sh_cols     = 0;
    phase_items = 0;
    #1;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity rotation: corners, center, overwrite, ignored and out-of-range items
    write_config(1 << FracW, 0, 0, 0);
    send_item(REQ_LOAD, 0, 0, 'hFF, 1'b1);
    send_item(REQ_LOAD, 27, 27, 'h00, 1'b1);
    send_item(REQ_LOAD, 27, 0, 'hAA, 1'b1);
    send_item(REQ_LOAD, 0, 27, 'h55, 1'b1);
    send_item(REQ_LOAD, 14, 14, 'h81, 1'b1);
    send_item(REQ_LOAD, 3, 4, 'h7E, 1'b1);
    send_item(REQ_LOAD, 3, 4, 'h18, 1'b1);   // later writer wins
    send_item(REQ_READ, 0, 0, 'h00, 1'b1);
    send_item(REQ_READ, 27, 27, 'hFF, 1'b1);
    send_item(REQ_READ, 27, 0, 'h00, 1'b1);
    send_item(REQ_READ, 0, 27, 'h00, 1'b1);
    send_item(REQ_READ, 14, 14, 'h00, 1'b1);
    send_item(REQ_READ, 3, 4, 'h00, 1'b1);
    send_item(REQ_LOAD, 31, 31, 'hFF, 1'b0);
    send_item(REQ_LOAD, 5, 28, 'h11, 1'b0);
    send_item(REQ_READ, 31, 31, 'hFF, 1'b1);
    send_item(REQ_READ, 0, 28, 'h00, 1'b1);
    send_item(ReqUnused, 31, 31, 'hFF, 1'b0);
    send_item(REQ_CLEAR, 31, 31, 'hFF, 1'b1);
    send_item(REQ_READ, 0, 0, 'h00, 1'b1);    // flag cleared, store still holds data
    send_item(REQ_READ, 14, 14, 'hFF, 1'b1);
    wait_drained();

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: write_config(11585, 11585, -5, 5);     // 45 degrees, shifts of -5 rows and 5 columns
        1: write_config(0, 16384, 5, -5);         // 90 degrees
        2: write_config(-16384, 0, 0, 0);         // 180 degrees
        3: write_config(14189, -8192, 3, -2);
        4: write_config(0, -16384, -1, 4);
        5: write_config(16384, 0, 2, 1);
        6: write_config(15137, 6270, -3, 0);
        7: write_config(32767, -32768, 7, -8);    // beyond the nominal range
        default: write_config($urandom, $urandom, $urandom, $urandom);
      endcase
      no_gaps <= (p == 2);
      if (p == 4) hold_go <= 1'b1;
      // enough clears to wrap the store generation tag
      if (p == 5) repeat (260) send_item(REQ_CLEAR, $urandom, $urandom, $urandom, 1'b0);
      run_phase(PhaseItems);
      wait_drained();
    end

    if (err_count == 0 && pending == 0)
      $display("image_rotate_shift_augment_core: match");
    else
      $display("image_rotate_shift_augment_core: mismatch");
    $finish;
  end

endmodule
